// ===== hdl/c2p_pkg.sv =====
`default_nettype none
package c2p_pkg;

    // Coordinate and fixed-point formats
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;

    // b of the rational arctangent, unsigned Q0.16
    localparam logic [16:0] B_Q16 = 17'd39074;

    // Datapath widths
    localparam int ROOT_W    = 24;                 // radius bits, one per recurrence stage
    localparam int SQ_W      = 49;                 // square-root remainder
    localparam int DEN_W     = 49;                 // angle denominator
    localparam int DIV_W     = 64;                 // angle dividend / remainder
    localparam int QUOT_W    = 15;                 // angle magnitude bits
    localparam int DIV_START = ROOT_W - QUOT_W;    // first stage that takes a quotient bit

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
    } point_t;

    typedef struct packed {
        logic [23:0]        radius;
        logic signed [15:0] angle_deg;
        logic               at_origin;
    } polar_t;

    // Per-stage state of the shared square-root / divide recurrence
    typedef struct packed {
        logic [SQ_W-1:0]   rad_rem;
        logic [ROOT_W-1:0] root;
        logic [DIV_W-1:0]  div_rem;
        logic [DEN_W-1:0]  den;
        logic [QUOT_W-1:0] quot;
        logic              neg;
        logic              origin;
    } work_t;

endpackage
`default_nettype wire

// ===== hdl/cartesian_to_polar.sv =====
// Cartesian-to-polar converter. Pulse start with a point on coord; at the end of the pipeline
// done is high for one cycle with the radius (floor, 8 fraction bits), the angle in Q8.8
// degrees and the origin flag on result. A new point may be started every cycle and busy
// is always low. A point passes five multiply and scaling stages, the 24-stage square-root
// recurrence (one root bit per stage; the last 15 stages also retire one angle quotient bit
// each) and one output register. The receiver cannot stall: each result is shown for one
// cycle only and must be taken then.
`default_nettype none
module cartesian_to_polar (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire c2p_pkg::point_t coord,
    output c2p_pkg::polar_t      result,
    output logic                 done
);

    logic           front_valid, recur_valid;
    c2p_pkg::work_t front_work, recur_work;
    c2p_pkg::polar_t result_reg, result_next;
    logic           done_reg;
    logic [15:0]    angle_mag;

    c2p_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .coord     (coord),
        .out_valid (front_valid),
        .work      (front_work)
    );

    c2p_recur u_recur (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .work_in   (front_work),
        .out_valid (recur_valid),
        .work_out  (recur_work)
    );

    // sign restore and origin override
    always_comb
    begin
        angle_mag = {1'b0, recur_work.quot};
        result_next.radius    = recur_work.root;
        result_next.angle_deg = recur_work.neg ? $signed(-angle_mag) : $signed(angle_mag);
        result_next.at_origin = recur_work.origin;
        if (recur_work.origin)
        begin
            result_next.radius    = '0;
            result_next.angle_deg = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= recur_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== hdl/c2p_front.sv =====
`default_nettype none
module c2p_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire c2p_pkg::point_t coord,
    output logic                 out_valid,
    output c2p_pkg::work_t       work
);

    logic [4:0] valid_reg;

    // stage 1: capture
    logic signed [15:0] x1_reg, y1_reg;
    // stage 2: products
    logic [30:0]        xx2_reg, yy2_reg;
    logic signed [31:0] xy2_reg;
    logic               org2_reg;
    // stage 3: sum of squares and b*x*y
    logic [32:0]        s3_reg;
    logic [30:0]        yy3_reg;
    logic signed [49:0] bxy3_reg;
    logic               org3_reg;
    // stage 4: numerator and denominator
    logic signed [49:0] num4_reg;
    logic [48:0]        den4_reg;
    logic [47:0]        v4_reg;
    logic               org4_reg;
    // stage 5: scaled dividend
    logic [63:0]        p5_reg;
    logic [48:0]        den5_reg;
    logic [47:0]        v5_reg;
    logic               neg5_reg;
    logic               org5_reg;

    logic signed [31:0] xx_full, yy_full;
    logic signed [49:0] bxy_next;
    logic signed [49:0] num_next, den_next;
    logic [48:0]        num_mag;
    logic [63:0]        m64;
    logic [63:0]        p_next;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // arithmetic per stage
    always_comb
    begin
        xx_full  = x1_reg * x1_reg;
        yy_full  = y1_reg * y1_reg;
        bxy_next = 50'(xy2_reg * $signed({1'b0, c2p_pkg::B_Q16}));
        num_next = bxy3_reg + $signed({3'b0, yy3_reg, 16'b0});
        den_next = (bxy3_reg <<< 1) + $signed({1'b0, s3_reg, 16'b0});
        num_mag  = num4_reg[49] ? 49'(-num4_reg) : num4_reg[48:0];
        m64      = {15'b0, num_mag};
        // 90 = 64 + 16 + 8 + 2, then Q8 scale
        p_next   = ((m64 << 6) + (m64 << 4) + (m64 << 3) + (m64 << 1)) << 8;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x1_reg   <= coord.x_coord;
        y1_reg   <= coord.y_coord;

        xx2_reg  <= xx_full[30:0];
        yy2_reg  <= yy_full[30:0];
        xy2_reg  <= x1_reg * y1_reg;
        org2_reg <= (x1_reg == '0) && (y1_reg == '0);

        s3_reg   <= {2'b0, xx2_reg} + {2'b0, yy2_reg};
        yy3_reg  <= yy2_reg;
        bxy3_reg <= bxy_next;
        org3_reg <= org2_reg;

        num4_reg <= num_next;
        den4_reg <= den_next[48:0];
        v4_reg   <= {s3_reg[31:0], 16'b0};
        org4_reg <= org3_reg;

        p5_reg   <= p_next;
        den5_reg <= den4_reg;
        v5_reg   <= v4_reg;
        neg5_reg <= num4_reg[49];
        org5_reg <= org4_reg;
    end

    assign out_valid    = valid_reg[4];
    assign work.rad_rem = {1'b0, v5_reg};
    assign work.root    = '0;
    assign work.div_rem = p5_reg;
    assign work.den     = den5_reg;
    assign work.quot    = '0;
    assign work.neg     = neg5_reg;
    assign work.origin  = org5_reg;

endmodule
`default_nettype wire

// ===== hdl/c2p_recur.sv =====
`default_nettype none
module c2p_recur (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire c2p_pkg::work_t work_in,
    output logic                out_valid,
    output c2p_pkg::work_t      work_out
);

    c2p_pkg::work_t stage_reg [1:c2p_pkg::ROOT_W];
    logic [c2p_pkg::ROOT_W:1] valid_reg;

    // One root bit per stage; the later stages also take one quotient bit
    for (genvar k = 0; k < c2p_pkg::ROOT_W; k++)
    begin : g_stage
        localparam int I = c2p_pkg::ROOT_W - 1 - k;

        c2p_pkg::work_t            stage_cur;
        logic                      valid_cur;
        c2p_pkg::work_t            stage_next;
        logic [c2p_pkg::SQ_W-1:0]  trial;
        logic [c2p_pkg::DIV_W-1:0] dsub;

        // stage input: module input for the first stage, previous register otherwise
        if (k == 0)
        begin : g_head
            assign stage_cur = work_in;
            assign valid_cur = in_valid;
        end
        else
        begin : g_tail
            assign stage_cur = stage_reg[k];
            assign valid_cur = valid_reg[k];
        end

        always_comb
        begin
            stage_next = stage_cur;
            trial = (c2p_pkg::SQ_W'(stage_cur.root) << (I + 1))
                  + (c2p_pkg::SQ_W'(1) << (2 * I));
            dsub  = c2p_pkg::DIV_W'(stage_cur.den) << ((I < c2p_pkg::QUOT_W) ? I : 0);
            if (stage_cur.rad_rem >= trial)
            begin
                stage_next.rad_rem = stage_cur.rad_rem - trial;
                stage_next.root[I] = 1'b1;
            end
            if (k >= c2p_pkg::DIV_START)
            begin
                if (stage_cur.div_rem >= dsub)
                begin
                    stage_next.div_rem = stage_cur.div_rem - dsub;
                    stage_next.quot[(I < c2p_pkg::QUOT_W) ? I : 0] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[k+1] <= stage_next;
        end
    end

    assign out_valid = valid_reg[c2p_pkg::ROOT_W];
    assign work_out  = stage_reg[c2p_pkg::ROOT_W];

endmodule
`default_nettype wire

// ===== hdl/c2p_checker.sv =====
`default_nettype none
module c2p_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            start,
    input wire logic            busy,
    input wire c2p_pkg::point_t coord,
    input wire c2p_pkg::polar_t result,
    input wire logic            done
);

    // fully pipelined: never refuses a transaction
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");

    a_origin_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && coord.x_coord == 0 && coord.y_coord == 0 |-> ##30
        done && result.at_origin && result.radius == 0 && result.angle_deg == 0)
        else $error("origin point gave wrong result");

    a_on_axis: assert property (@(posedge clk) disable iff (!rst_n)
        start && coord.x_coord == 0 && coord.y_coord != 0 |-> ##30
        done && !result.at_origin && result.angle_deg == 16'h5A00)
        else $error("point on y axis did not give 90 degrees");

    a_nonzero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.at_origin |-> result.radius != 0)
        else $error("zero radius away from origin");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##30 done)
        else $error("result missing after start");

endmodule

bind cartesian_to_polar c2p_checker u_c2p_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .coord  (coord),
    .result (result),
    .done   (done)
);
`default_nettype wire
